[hw/rtl/pnb_pkg.sv]
// ============================================================================
// pnb_pkg
// Shared widths, result kinds and register indexes of the page nursery
// bump allocator.
// ============================================================================
`default_nettype none

package pnb_pkg;

  // Field widths of the input, result and configuration transfers.
  localparam int MODE_W  = 1;
  localparam int SIZE_W  = 32;
  localparam int ALIGN_W = 5;
  localparam int KIND_W  = 3;
  localparam int SLOTF_W = 5;
  localparam int OFF_W   = 17;
  localparam int MAP_W   = 33;
  localparam int PL_W    = 5;
  localparam int HDR_W   = 7;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 7;

  // Saturation limits and reset values of the registers.
  localparam logic [PL_W-1:0]  PL_MIN    = 5'd12;
  localparam logic [PL_W-1:0]  PL_MAX    = 5'd16;
  localparam logic [PL_W-1:0]  PL_RESET  = 5'd12;
  localparam logic [HDR_W-1:0] HDR_MIN   = 7'd8;
  localparam logic [HDR_W-1:0] HDR_MAX   = 7'd64;
  localparam logic [HDR_W-1:0] HDR_RESET = 7'd16;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_OPEN      = 3'd0,
    KIND_FRESH     = 3'd1,
    KIND_LARGE     = 3'd2,
    KIND_RELEASED  = 3'd3,
    KIND_RETIRED   = 3'd4,
    KIND_REJECT    = 3'd5,
    KIND_FLUSH_END = 3'd6
  } kind_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_PAGE_SIZE_LOG2 = 2'd0,
    CFG_HEADER_BYTES   = 2'd1,
    CFG_EXECUTABLE     = 2'd2
  } cfg_idx_t;

endpackage

`default_nettype wire

[hw/rtl/pnb_ifs.sv]
// ============================================================================
// pnb_ifs
// Valid/ready channels of the allocator: request, response and register
// write.
// ============================================================================
`default_nettype none

interface pnb_in_if;
  logic                         valid;
  logic                         ready;
  logic [pnb_pkg::MODE_W-1:0]   mode;
  logic [pnb_pkg::SIZE_W-1:0]   size;
  logic [pnb_pkg::ALIGN_W-1:0]  align_log2;

  modport source (output valid, output mode, output size, output align_log2,
                  input ready);
  modport sink   (input valid, input mode, input size, input align_log2,
                  output ready);
endinterface

interface pnb_out_if;
  logic                         valid;
  logic                         ready;
  logic [pnb_pkg::KIND_W-1:0]   kind;
  logic [pnb_pkg::SLOTF_W-1:0]  slot;
  logic [pnb_pkg::OFF_W-1:0]    offset;
  logic [pnb_pkg::MAP_W-1:0]    map_bytes;
  logic                         retired_before;
  logic                         protect;
  logic                         last;

  modport source (output valid, output kind, output slot, output offset,
                  output map_bytes, output retired_before, output protect,
                  output last, input ready);
  modport sink   (input valid, input kind, input slot, input offset,
                  input map_bytes, input retired_before, input protect,
                  input last, output ready);
endinterface

interface pnb_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [pnb_pkg::CIDX_W-1:0]   index;
  logic [pnb_pkg::CDATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/page_nursery_bump_allocator_unit.sv]
// ============================================================================
// page_nursery_bump_allocator_unit
// Bump allocator over a row of open page slots, with large-mapping,
// fresh-page, retire and flush handling.
// ============================================================================
//
//  Channel | Dir | Payload                                        | Per item
//  --------+-----+------------------------------------------------+-----------
//  req     | in  | mode, size, align_log2                         | one
//  rsp     | out | kind, slot, offset, map_bytes, retired_before, | 1 or more,
//          |     | protect, last                                  | last marked
//  cfg     | in  | index, data                                    | one write
//
// An allocate request that misses every open page scans the fills of all
// slots, and an early hit ends the scan sooner; the fill scan reads one slot
// per cycle from the fill memory through a single round-up and compare unit.
// A flush steps through every slot and emits one transfer per slot in use.
// Reset is synchronous and clears the used bits and the registers; the fill
// memory is not cleared, since a fill is only ever read for a slot in use.
// Stalls on rsp hold the sequencer in its emit state, and req is taken again
// once the final transfer of an item sits in the output register.
//
`default_nettype none

module page_nursery_bump_allocator_unit #(
  parameter int SLOTS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  pnb_in_if.sink     req,
  pnb_out_if.source  rsp,
  pnb_cfg_if.sink    cfg
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOT_CNT = CNT_W'(SLOTS);
  localparam int OFF_W  = pnb_pkg::OFF_W;

  // One-hot sequencer states.
  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_SETUP  = 11'b000_0000_0010,
    ST_PREP   = 11'b000_0000_0100,
    ST_SCAN   = 11'b000_0000_1000,
    ST_HIT    = 11'b000_0001_0000,
    ST_FRESH  = 11'b000_0010_0000,
    ST_LARGE  = 11'b000_0100_0000,
    ST_REJECT = 11'b000_1000_0000,
    ST_FSTEP  = 11'b001_0000_0000,
    ST_FEMIT  = 11'b010_0000_0000,
    ST_FEND   = 11'b100_0000_0000
  } state_t;

  // Configuration registers, kept raw and saturated on use.
  logic [pnb_pkg::PL_W-1:0]  pl_raw;
  logic [pnb_pkg::HDR_W-1:0] hdr_raw;
  logic                      executable;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pl_raw     <= pnb_pkg::PL_RESET;
      hdr_raw    <= pnb_pkg::HDR_RESET;
      executable <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        pnb_pkg::CFG_PAGE_SIZE_LOG2: pl_raw     <= cfg.data[pnb_pkg::PL_W-1:0];
        pnb_pkg::CFG_HEADER_BYTES:   hdr_raw    <= cfg.data[pnb_pkg::HDR_W-1:0];
        pnb_pkg::CFG_EXECUTABLE:     executable <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Saturated page size and header, and the page size in bytes.
  logic [pnb_pkg::PL_W-1:0]  pl;
  logic [pnb_pkg::HDR_W-1:0] hdr;
  logic [OFF_W-1:0]          page_bytes;

  always_comb begin
    if (pl_raw < pnb_pkg::PL_MIN)      pl = pnb_pkg::PL_MIN;
    else if (pl_raw > pnb_pkg::PL_MAX) pl = pnb_pkg::PL_MAX;
    else                               pl = pl_raw;
    if (hdr_raw < pnb_pkg::HDR_MIN)      hdr = pnb_pkg::HDR_MIN;
    else if (hdr_raw > pnb_pkg::HDR_MAX) hdr = pnb_pkg::HDR_MAX;
    else                                 hdr = hdr_raw;
  end

  assign page_bytes = OFF_W'(1) << pl;

  // Sequencer and working registers.
  state_t                      state, state_next;
  logic                        mode_r, mode_r_next;
  logic [pnb_pkg::SIZE_W-1:0]  size_r, size_r_next;
  logic [pnb_pkg::ALIGN_W-1:0] al_r, al_r_next;
  logic [OFF_W-1:0]            mask_r, mask_r_next;
  logic [OFF_W-1:0]            hdr_al, hdr_al_next;
  logic [OFF_W-1:0]            limit, limit_next;
  logic [CNT_W-1:0]            idx, idx_next;
  logic [SLOT_W-1:0]           cidx, cidx_next;
  logic                        cvalid, cvalid_next;
  logic                        empty_ok, empty_ok_next;
  logic [SLOT_W-1:0]           empty_idx, empty_idx_next;
  logic                        full_ok, full_ok_next;
  logic [SLOT_W-1:0]           full_idx, full_idx_next;
  logic [OFF_W-1:0]            full_fill, full_fill_next;
  logic [SLOT_W-1:0]           hit_slot, hit_slot_next;
  logic [OFF_W-1:0]            hit_off, hit_off_next;

  // Output register.
  logic                         o_valid, o_valid_next;
  pnb_pkg::kind_t               o_kind, o_kind_next;
  logic [pnb_pkg::SLOTF_W-1:0]  o_slot, o_slot_next;
  logic [OFF_W-1:0]             o_offset, o_offset_next;
  logic [pnb_pkg::MAP_W-1:0]    o_map, o_map_next;
  logic                         o_ret, o_ret_next;
  logic                         o_prot, o_prot_next;
  logic                         o_last, o_last_next;

  // Slot state: used bits in flops, fills in a memory with a registered read.
  logic [SLOTS-1:0]  used;
  logic [OFF_W-1:0]  fill_mem [SLOTS];
  logic [OFF_W-1:0]  rd_data;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [OFF_W-1:0]  wr_data;
  logic              set_used, clr_used;
  logic [SLOT_W-1:0] used_addr;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fill_mem[wr_addr] <= wr_data;
    end
    rd_data <= fill_mem[idx[SLOT_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (set_used) begin
      used[used_addr] <= 1'b1;
    end else if (clr_used) begin
      used[used_addr] <= 1'b0;
    end
  end

  // The shared scan unit: round a fill up to the alignment and compare it
  // against the room left for the request.
  logic [OFF_W:0] rnd_sum;
  logic [OFF_W:0] rnd;
  logic           fits;

  assign rnd_sum = (OFF_W + 1)'(rd_data) + (OFF_W + 1)'(mask_r);
  assign rnd     = rnd_sum & ~{1'b0, mask_r};
  assign fits    = rnd <= (OFF_W + 1)'(limit);

  logic out_free;
  logic req_fire;
  logic scan_done;

  assign out_free  = !o_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign scan_done = !cvalid && (idx == SLOT_CNT);

  always_comb begin
    state_next     = state;
    mode_r_next    = mode_r;
    size_r_next    = size_r;
    al_r_next      = al_r;
    mask_r_next    = mask_r;
    hdr_al_next    = hdr_al;
    limit_next     = limit;
    idx_next       = idx;
    cidx_next      = cidx;
    cvalid_next    = 1'b0;
    empty_ok_next  = empty_ok;
    empty_idx_next = empty_idx;
    full_ok_next   = full_ok;
    full_idx_next  = full_idx;
    full_fill_next = full_fill;
    hit_slot_next  = hit_slot;
    hit_off_next   = hit_off;

    o_valid_next  = o_valid && !rsp.ready;
    o_kind_next   = o_kind;
    o_slot_next   = o_slot;
    o_offset_next = o_offset;
    o_map_next    = o_map;
    o_ret_next    = o_ret;
    o_prot_next   = o_prot;
    o_last_next   = o_last;

    wr_en     = 1'b0;
    wr_addr   = hit_slot;
    wr_data   = hit_off;
    set_used  = 1'b0;
    clr_used  = 1'b0;
    used_addr = idx[SLOT_W-1:0];

    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          mode_r_next = req.mode;
          size_r_next = req.size;
          al_r_next   = req.align_log2;
          state_next  = ST_SETUP;
        end
      end

      ST_SETUP: begin
        idx_next = '0;
        if (mode_r == pnb_pkg::MODE_FLUSH) begin
          state_next = ST_FSTEP;
        end else if (al_r > pl) begin
          state_next = ST_REJECT;
        end else begin
          // The alignment is at most the page size here, so it fits 17 bits.
          mask_r_next = (OFF_W'(1) << al_r) - OFF_W'(1);
          hdr_al_next = (OFF_W'(hdr) + mask_r_next) & ~mask_r_next;
          state_next  = ST_PREP;
        end
      end

      ST_PREP: begin
        // The aligned header never exceeds the page, so the room is not negative.
        if ((pnb_pkg::MAP_W)'(size_r) >= (pnb_pkg::MAP_W)'(page_bytes - hdr_al)) begin
          state_next = ST_LARGE;
        end else begin
          limit_next    = page_bytes - size_r[OFF_W-1:0];
          idx_next      = '0;
          empty_ok_next = 1'b0;
          full_ok_next  = 1'b0;
          state_next    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle; the compare stage handles each read in the next cycle.
        if (idx != SLOT_CNT) begin
          idx_next    = idx + CNT_W'(1);
          cidx_next   = idx[SLOT_W-1:0];
          cvalid_next = 1'b1;
        end
        if (cvalid) begin
          if (used[cidx]) begin
            if (fits) begin
              hit_slot_next = cidx;
              hit_off_next  = rnd[OFF_W-1:0];
              cvalid_next   = 1'b0;
              state_next    = ST_HIT;
            end else if (!full_ok || full_fill < rd_data) begin
              full_ok_next   = 1'b1;
              full_idx_next  = cidx;
              full_fill_next = rd_data;
            end
          end else if (!empty_ok) begin
            empty_ok_next  = 1'b1;
            empty_idx_next = cidx;
          end
        end else if (scan_done) begin
          state_next = ST_FRESH;
        end
      end

      ST_HIT: begin
        if (out_free) begin
          wr_en         = 1'b1;
          wr_addr       = hit_slot;
          wr_data       = hit_off + size_r[OFF_W-1:0];
          o_valid_next  = 1'b1;
          o_kind_next   = pnb_pkg::KIND_OPEN;
          o_slot_next   = pnb_pkg::SLOTF_W'(hit_slot);
          o_offset_next = hit_off;
          o_map_next    = '0;
          o_ret_next    = 1'b0;
          o_prot_next   = 1'b0;
          o_last_next   = 1'b1;
          state_next    = ST_IDLE;
        end
      end

      ST_FRESH: begin
        // With no empty slot every slot is in use, so the fullest one is known.
        if (out_free) begin
          wr_en         = 1'b1;
          wr_addr       = empty_ok ? empty_idx : (full_ok ? full_idx : '0);
          wr_data       = hdr_al + size_r[OFF_W-1:0];
          set_used      = 1'b1;
          used_addr     = wr_addr;
          o_valid_next  = 1'b1;
          o_kind_next   = pnb_pkg::KIND_FRESH;
          o_slot_next   = pnb_pkg::SLOTF_W'(wr_addr);
          o_offset_next = hdr_al;
          o_map_next    = '0;
          o_ret_next    = !empty_ok;
          o_prot_next   = 1'b0;
          o_last_next   = 1'b1;
          state_next    = ST_IDLE;
        end
      end

      ST_LARGE: begin
        if (out_free) begin
          o_valid_next  = 1'b1;
          o_kind_next   = pnb_pkg::KIND_LARGE;
          o_slot_next   = '0;
          o_offset_next = hdr_al;
          o_map_next    = (pnb_pkg::MAP_W)'(hdr_al) + (pnb_pkg::MAP_W)'(size_r);
          o_ret_next    = 1'b0;
          o_prot_next   = 1'b0;
          o_last_next   = 1'b1;
          state_next    = ST_IDLE;
        end
      end

      ST_REJECT: begin
        if (out_free) begin
          o_valid_next  = 1'b1;
          o_kind_next   = pnb_pkg::KIND_REJECT;
          o_slot_next   = '0;
          o_offset_next = '0;
          o_map_next    = '0;
          o_ret_next    = 1'b0;
          o_prot_next   = 1'b0;
          o_last_next   = 1'b1;
          state_next    = ST_IDLE;
        end
      end

      ST_FSTEP: begin
        // Skip free slots; a used slot goes to the emit state, where its fill read is ready.
        if (idx == SLOT_CNT) begin
          state_next = ST_FEND;
        end else if (used[idx[SLOT_W-1:0]]) begin
          state_next = ST_FEMIT;
        end else begin
          idx_next = idx + CNT_W'(1);
        end
      end

      ST_FEMIT: begin
        if (out_free) begin
          clr_used      = 1'b1;
          used_addr     = idx[SLOT_W-1:0];
          o_valid_next  = 1'b1;
          o_kind_next   = (rd_data == OFF_W'(hdr)) ? pnb_pkg::KIND_RELEASED
                                                   : pnb_pkg::KIND_RETIRED;
          o_slot_next   = pnb_pkg::SLOTF_W'(idx[SLOT_W-1:0]);
          o_offset_next = '0;
          o_map_next    = '0;
          o_ret_next    = 1'b0;
          o_prot_next   = 1'b0;
          o_last_next   = 1'b0;
          idx_next      = idx + CNT_W'(1);
          state_next    = ST_FSTEP;
        end
      end

      ST_FEND: begin
        if (out_free) begin
          o_valid_next  = 1'b1;
          o_kind_next   = pnb_pkg::KIND_FLUSH_END;
          o_slot_next   = '0;
          o_offset_next = '0;
          o_map_next    = '0;
          o_ret_next    = 1'b0;
          o_prot_next   = executable;
          o_last_next   = 1'b1;
          state_next    = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cvalid  <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      cvalid  <= cvalid_next;
      o_valid <= o_valid_next;
    end
    mode_r    <= mode_r_next;
    size_r    <= size_r_next;
    al_r      <= al_r_next;
    mask_r    <= mask_r_next;
    hdr_al    <= hdr_al_next;
    limit     <= limit_next;
    idx       <= idx_next;
    cidx      <= cidx_next;
    empty_ok  <= empty_ok_next;
    empty_idx <= empty_idx_next;
    full_ok   <= full_ok_next;
    full_idx  <= full_idx_next;
    full_fill <= full_fill_next;
    hit_slot  <= hit_slot_next;
    hit_off   <= hit_off_next;
    o_kind    <= o_kind_next;
    o_slot    <= o_slot_next;
    o_offset  <= o_offset_next;
    o_map     <= o_map_next;
    o_ret     <= o_ret_next;
    o_prot    <= o_prot_next;
    o_last    <= o_last_next;
  end

  assign rsp.valid          = o_valid;
  assign rsp.kind           = o_kind;
  assign rsp.slot           = o_slot;
  assign rsp.offset         = o_offset;
  assign rsp.map_bytes      = o_map;
  assign rsp.retired_before = o_ret;
  assign rsp.protect        = o_prot;
  assign rsp.last           = o_last;

endmodule

`default_nettype wire

[hw/rtl/pnb_checker.sv]
// ============================================================================
// pnb_checker
// Port-level checks of the allocator, attached to the top level by bind.
// ============================================================================
`default_nettype none

module pnb_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [pnb_pkg::KIND_W-1:0]  out_kind,
  input wire logic                        out_retired,
  input wire logic                        out_last
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("response dropped while stalled");

  // The block works on one item at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // Per-slot flush results are never final; every other kind is.
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == !(out_kind == pnb_pkg::KIND_RELEASED ||
                                 out_kind == pnb_pkg::KIND_RETIRED)))
    else $error("last flag does not match result kind");

  // Retirement to make room only comes with a fresh page.
  a_retired: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_retired |-> out_kind == pnb_pkg::KIND_FRESH)
    else $error("retired flag on a result that is not a fresh page");

endmodule

bind page_nursery_bump_allocator_unit pnb_checker u_pnb_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready),
  .out_kind    (rsp.kind),
  .out_retired (rsp.retired_before),
  .out_last    (rsp.last)
);

`default_nettype wire

[tb/sv/tb_top.sv]
// ============================================================================
// tb_top
// Self-checking bench for the page nursery bump allocator: a directed table of
// corner requests, then seven register settings, each with a randomized burst
// of allocate and flush requests, checked against a cycle-free predictor.
// ============================================================================

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT  = 32;
  localparam int NPHASE = 7;

  // Register values written at the start of each phase. Phase 0 runs on the
  // reset values and writes nothing. Out-of-range values exercise the
  // saturation of the page size and header registers.
  localparam int PHASE_PL[NPHASE]    = '{12, 0, 16, 127, 14, 15, 12};
  localparam int PHASE_HDR[NPHASE]   = '{16, 0, 64, 127, 33, 7, 64};
  localparam int PHASE_EXEC[NPHASE]  = '{0, 1, 0, 127, 0, 1, 0};
  localparam int PHASE_ITEMS[NPHASE] = '{50, 70, 45, 70, 45, 70, 45};

  typedef struct {
    pnb_pkg::kind_t               kind;
    logic [pnb_pkg::SLOTF_W-1:0]  slot;
    logic [pnb_pkg::OFF_W-1:0]    offset;
    logic [pnb_pkg::MAP_W-1:0]    map_bytes;
    logic                         retired_before;
    logic                         protect;
    logic                         last;
  } rsp_t;

  typedef struct {
    logic                         mode;
    logic [pnb_pkg::SIZE_W-1:0]   size;
    logic [pnb_pkg::ALIGN_W-1:0]  align_log2;
    bit                           typed;
    rsp_t                         want;
  } stim_row_t;

  logic clk;
  logic rst;

  pnb_in_if  req_if ();
  pnb_out_if rsp_if ();
  pnb_cfg_if cfg_if ();

  page_nursery_bump_allocator_unit #(
    .SLOTS (NSLOT)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  // Shadow of the block: register copies and the slot table.
  logic [pnb_pkg::PL_W-1:0]   reg_page_log2 = pnb_pkg::PL_RESET;
  logic [pnb_pkg::HDR_W-1:0]  reg_header    = pnb_pkg::HDR_RESET;
  logic                       reg_exec      = 1'b0;
  bit                         slot_used [NSLOT];
  logic [pnb_pkg::OFF_W-1:0]  slot_fill [NSLOT];

  // Results predicted for accepted requests, oldest first.
  rsp_t pending_rsp[$];
  int   error_count = 0;

  // Idle behavior of both sides, switched per phase.
  bit req_gaps_on   = 1'b1;
  bit rsp_stalls_on = 1'b1;

  rsp_t no_check;

  initial begin : clock_gen
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run. The slowest legal run (every item a full flush
  // with every transfer stalled) stays well below this.
  initial begin : watchdog
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic rsp_t mk_rsp(pnb_pkg::kind_t k, int unsigned slot,
                                  longint unsigned off, longint unsigned map,
                                  bit ret, bit prot, bit last);
    rsp_t r;
    r.kind           = k;
    r.slot           = slot[pnb_pkg::SLOTF_W-1:0];
    r.offset         = off[pnb_pkg::OFF_W-1:0];
    r.map_bytes      = map[pnb_pkg::MAP_W-1:0];
    r.retired_before = ret;
    r.protect        = prot;
    r.last           = last;
    return r;
  endfunction

  function automatic stim_row_t stim_row(logic mode, logic [pnb_pkg::SIZE_W-1:0] size,
                                         logic [pnb_pkg::ALIGN_W-1:0] al, bit typed,
                                         rsp_t want);
    stim_row_t s;
    s.mode       = mode;
    s.size       = size;
    s.align_log2 = al;
    s.typed      = typed;
    s.want       = want;
    return s;
  endfunction

  function automatic longint unsigned align_up(longint unsigned x, longint unsigned a);
    return (x + a - 1) & ~(a - 1);
  endfunction

  // Page size and header as the block uses them, after saturation.
  function automatic int unsigned eff_page_log2();
    if (reg_page_log2 < pnb_pkg::PL_MIN) return pnb_pkg::PL_MIN;
    if (reg_page_log2 > pnb_pkg::PL_MAX) return pnb_pkg::PL_MAX;
    return reg_page_log2;
  endfunction

  function automatic int unsigned eff_header();
    if (reg_header < pnb_pkg::HDR_MIN) return pnb_pkg::HDR_MIN;
    if (reg_header > pnb_pkg::HDR_MAX) return pnb_pkg::HDR_MAX;
    return reg_header;
  endfunction

  // Works out the results of one accepted request and updates the shadow
  // slot table. A flush gives one result per open slot and then flush end;
  // an allocate request gives exactly one result.
  function automatic void nursery_step(logic mode, logic [pnb_pkg::SIZE_W-1:0] size,
                                       logic [pnb_pkg::ALIGN_W-1:0] al,
                                       ref rsp_t outs[$]);
    int unsigned       pl;
    int unsigned       hdr;
    longint unsigned   pg;
    longint unsigned   algn;
    longint unsigned   hdr_al;
    longint unsigned   f;
    int                empty_idx;
    int                full_idx;
    bit                ret;
    pl        = eff_page_log2();
    hdr       = eff_header();
    pg        = 64'd1 << pl;
    empty_idx = -1;
    full_idx  = -1;
    ret       = 1'b0;
    outs.delete();

    if (mode == pnb_pkg::MODE_FLUSH) begin
      // A page still holding only its header goes back as released.
      for (int i = 0; i < NSLOT; i++) begin
        if (slot_used[i]) begin
          outs.push_back(mk_rsp((slot_fill[i] == hdr) ? pnb_pkg::KIND_RELEASED
                                                      : pnb_pkg::KIND_RETIRED,
                                i, 0, 0, 0, 0, 0));
          slot_used[i] = 1'b0;
        end
      end
      outs.push_back(mk_rsp(pnb_pkg::KIND_FLUSH_END, 0, 0, 0, 0, reg_exec, 1));
      return;
    end

    // An alignment coarser than the page cannot be served at all.
    if (al > pl) begin
      outs.push_back(mk_rsp(pnb_pkg::KIND_REJECT, 0, 0, 0, 0, 0, 1));
      return;
    end

    algn   = 64'd1 << al;
    hdr_al = align_up(hdr, algn);

    if (size >= pg - hdr_al) begin
      outs.push_back(mk_rsp(pnb_pkg::KIND_LARGE, 0, hdr_al, hdr_al + size, 0, 0, 1));
      return;
    end

    // First open page with room after rounding its fill up wins. Along the
    // way, remember the first free slot and the fullest open page.
    for (int i = 0; i < NSLOT; i++) begin
      if (!slot_used[i]) begin
        if (empty_idx < 0) empty_idx = i;
        continue;
      end
      f = align_up(slot_fill[i], algn);
      if (f <= pg && size <= pg - f) begin
        slot_fill[i] = pnb_pkg::OFF_W'(f + size);
        outs.push_back(mk_rsp(pnb_pkg::KIND_OPEN, i, f, 0, 0, 0, 1));
        return;
      end
      if (full_idx < 0 || slot_fill[full_idx] < slot_fill[i]) full_idx = i;
    end

    if (empty_idx < 0) begin
      empty_idx = (full_idx < 0) ? 0 : full_idx;
      ret       = 1'b1;
    end
    slot_used[empty_idx] = 1'b1;
    slot_fill[empty_idx] = pnb_pkg::OFF_W'(hdr_al + size);
    outs.push_back(mk_rsp(pnb_pkg::KIND_FRESH, empty_idx, hdr_al, 0, ret, 0, 1));
  endfunction

  // Offers one request, waits for its transfer and records what it must
  // produce. Rows of the directed table may carry a hand-written result; the
  // predictor still runs on them so that the slot table stays in step.
  task automatic send_req(logic mode, logic [pnb_pkg::SIZE_W-1:0] size,
                          logic [pnb_pkg::ALIGN_W-1:0] al, bit typed, rsp_t want);
    rsp_t outs[$];
    int   gap;
    gap = req_gaps_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.mode       <= mode;
    req_if.size       <= size;
    req_if.align_log2 <= al;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    nursery_step(mode, size, al, outs);
    if (typed) begin
      pending_rsp.push_back(want);
    end else begin
      foreach (outs[i]) pending_rsp.push_back(outs[i]);
    end
  endtask

  // One register write transfer; the shadow copy takes the masked value.
  task automatic cfg_write(pnb_pkg::cfg_idx_t idx, logic [pnb_pkg::CDATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      pnb_pkg::CFG_PAGE_SIZE_LOG2: reg_page_log2 = data[pnb_pkg::PL_W-1:0];
      pnb_pkg::CFG_HEADER_BYTES:   reg_header    = data[pnb_pkg::HDR_W-1:0];
      pnb_pkg::CFG_EXECUTABLE:     reg_exec      = data[0];
      default: ;
    endcase
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // Response side: draws a stall before each transfer, then compares the
  // transfer with the oldest prediction.
  initial begin : rsp_checker
    int   stall;
    rsp_t want;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = rsp_stalls_on ? $urandom_range(0, 8) : 0;
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_if.valid) @(posedge clk);
      if (pending_rsp.size() == 0) begin
        $error("unexpected result: kind %0d slot %0d", rsp_if.kind, rsp_if.slot);
        error_count++;
      end else begin
        want = pending_rsp.pop_front();
        check_field("kind",           want.kind,           rsp_if.kind);
        check_field("slot",           want.slot,           rsp_if.slot);
        check_field("offset",         want.offset,         rsp_if.offset);
        check_field("map_bytes",      want.map_bytes,      rsp_if.map_bytes);
        check_field("retired_before", want.retired_before, rsp_if.retired_before);
        check_field("protect",        want.protect,        rsp_if.protect);
        check_field("last",           want.last,           rsp_if.last);
      end
    end
  end

  initial begin : stimulus
    stim_row_t                    dir_rows[$];
    int                           flush_odds;
    int unsigned                  pl;
    longint unsigned              pg;
    logic                         mode;
    logic [pnb_pkg::SIZE_W-1:0]   size;
    logic [pnb_pkg::ALIGN_W-1:0]  al;

    // Every input of the block is known from time zero.
    rst               <= 1'b1;
    req_if.valid      <= 1'b0;
    req_if.mode       <= pnb_pkg::MODE_ALLOC;
    req_if.size       <= '0;
    req_if.align_log2 <= '0;
    rsp_if.ready      <= 1'b0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= pnb_pkg::CFG_PAGE_SIZE_LOG2;
    cfg_if.data       <= '0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed table, run on the reset registers: 4 KiB pages and a 16 byte
    // header. Where the outcome is obvious it is written out here.
    // The first request opens slot 0 with a page that holds only its header.
    dir_rows.push_back(stim_row(pnb_pkg::MODE_ALLOC, 32'd0, 5'd0, 1,
                                mk_rsp(pnb_pkg::KIND_FRESH, 0, 16, 0, 0, 0, 1)));
    // Largest size: always a large mapping, and the map width must hold it.
    dir_rows.push_back(stim_row(pnb_pkg::MODE_ALLOC, 32'hFFFF_FFFF, 5'd0, 1,
                                mk_rsp(pnb_pkg::KIND_LARGE, 0, 16, 33'h1_0000_000F,
                                       0, 0, 1)));
    // Alignments coarser than the page are rejected, up to the field maximum.
    dir_rows.push_back(stim_row(pnb_pkg::MODE_ALLOC, 32'd100, 5'd13, 1,
                                mk_rsp(pnb_pkg::KIND_REJECT, 0, 0, 0, 0, 0, 1)));
    dir_rows.push_back(stim_row(pnb_pkg::MODE_ALLOC, 32'd0, 5'd16, 1,
                                mk_rsp(pnb_pkg::KIND_REJECT, 0, 0, 0, 0, 0, 1)));
    dir_rows.push_back(stim_row(pnb_pkg::MODE_ALLOC, 32'd0, 5'd31, 1,
                                mk_rsp(pnb_pkg::KIND_REJECT, 0, 0, 0, 0, 0, 1)));
    // A page-sized alignment pushes the header to a whole page: even a zero
    // size becomes large.
    dir_rows.push_back(stim_row(pnb_pkg::MODE_ALLOC, 32'd0, 5'd12, 1,
                                mk_rsp(pnb_pkg::KIND_LARGE, 0, 4096, 4096, 0, 0, 1)));
    // Exactly at the large threshold, then one byte under it.
    dir_rows.push_back(stim_row(pnb_pkg::MODE_ALLOC, 32'd4080, 5'd0, 1,
                                mk_rsp(pnb_pkg::KIND_LARGE, 0, 16, 4096, 0, 0, 1)));
    dir_rows.push_back(stim_row(pnb_pkg::MODE_ALLOC, 32'd4079, 5'd0, 0, no_check));
    dir_rows.push_back(stim_row(pnb_pkg::MODE_ALLOC, 32'd1, 5'd4, 0, no_check));
    dir_rows.push_back(stim_row(pnb_pkg::MODE_ALLOC, 32'h5555_5555, 5'd0, 1,
                                mk_rsp(pnb_pkg::KIND_LARGE, 0, 16, 33'h0_5555_5565,
                                       0, 0, 1)));
    dir_rows.push_back(stim_row(pnb_pkg::MODE_ALLOC, 32'h0000_02AA, 5'd10, 0, no_check));
    dir_rows.push_back(stim_row(pnb_pkg::MODE_ALLOC, 32'h0000_0AAA, 5'd1, 0, no_check));
    // Flush with open pages, then a flush with nothing open gives only the
    // closing transfer; its size and alignment are don't-care.
    dir_rows.push_back(stim_row(pnb_pkg::MODE_FLUSH, 32'd0, 5'd0, 0, no_check));
    dir_rows.push_back(stim_row(pnb_pkg::MODE_FLUSH, 32'hFFFF_FFFF, 5'd31, 1,
                                mk_rsp(pnb_pkg::KIND_FLUSH_END, 0, 0, 0, 0, 0, 1)));
    // A header-only page in use must come back as released on flush.
    dir_rows.push_back(stim_row(pnb_pkg::MODE_ALLOC, 32'd0, 5'd3, 1,
                                mk_rsp(pnb_pkg::KIND_FRESH, 0, 16, 0, 0, 0, 1)));
    dir_rows.push_back(stim_row(pnb_pkg::MODE_FLUSH, 32'd0, 5'd0, 0, no_check));
    // A 32 byte alignment rounds the header up to 32.
    dir_rows.push_back(stim_row(pnb_pkg::MODE_ALLOC, 32'h8000_0000, 5'd5, 1,
                                mk_rsp(pnb_pkg::KIND_LARGE, 0, 32, 33'h0_8000_0020,
                                       0, 0, 1)));
    dir_rows.push_back(stim_row(pnb_pkg::MODE_ALLOC, 32'd0, 5'd5, 1,
                                mk_rsp(pnb_pkg::KIND_FRESH, 0, 32, 0, 0, 0, 1)));
    dir_rows.push_back(stim_row(pnb_pkg::MODE_ALLOC, 32'd7, 5'd2, 0, no_check));
    dir_rows.push_back(stim_row(pnb_pkg::MODE_ALLOC, 32'd4064, 5'd0, 0, no_check));
    dir_rows.push_back(stim_row(pnb_pkg::MODE_FLUSH, 32'd0, 5'd0, 0, no_check));

    for (int p = 0; p < NPHASE; p++) begin
      if (p > 0) begin
        // Registers only change once the block has drained, so the sender
        // holds off here until every predicted transfer has arrived.
        req_if.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge clk);
        cfg_write(pnb_pkg::CFG_PAGE_SIZE_LOG2, pnb_pkg::CDATA_W'(PHASE_PL[p]));
        cfg_write(pnb_pkg::CFG_HEADER_BYTES,   pnb_pkg::CDATA_W'(PHASE_HDR[p]));
        cfg_write(pnb_pkg::CFG_EXECUTABLE,     pnb_pkg::CDATA_W'(PHASE_EXEC[p]));
        cfg_if.valid <= 1'b0;
      end

      // Phases cycle through idling on both sides, none, sender only and
      // receiver only.
      req_gaps_on   = (p % 4 == 0) || (p % 4 == 2);
      rsp_stalls_on = (p % 4 == 0) || (p % 4 == 3);

      if (p == 0) begin
        foreach (dir_rows[i])
          send_req(dir_rows[i].mode, dir_rows[i].size, dir_rows[i].align_log2,
                   dir_rows[i].typed, dir_rows[i].want);
      end

      // Odd phases flush rarely, so the slot row fills up completely and the
      // fullest page has to be retired to make room.
      flush_odds = (p % 2 == 1) ? 100 : 15;

      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        pl = eff_page_log2();
        pg = 64'd1 << pl;
        if ($urandom_range(1, flush_odds) == 1) begin
          mode = pnb_pkg::MODE_FLUSH;
          size = $urandom();
          al   = pnb_pkg::ALIGN_W'($urandom());
        end else begin
          mode = pnb_pkg::MODE_ALLOC;
          // Mostly page-filling sizes so that fresh pages pile up, with
          // small bumps, sizes around the large threshold and raw words.
          case ($urandom_range(0, 9))
            0:       size = $urandom();
            1:       size = pnb_pkg::SIZE_W'(pg - $urandom_range(0, 130));
            2:       size = $urandom_range(0, 64);
            3, 4:    size = $urandom_range(0, int'(pg / 8));
            default: size = $urandom_range(int'(pg / 2), int'(pg - 1));
          endcase
          case ($urandom_range(0, 9))
            0:       al = pnb_pkg::ALIGN_W'($urandom_range(0, 31));
            1, 2:    al = pnb_pkg::ALIGN_W'($urandom_range(0, pl));
            default: al = pnb_pkg::ALIGN_W'($urandom_range(0, 4));
          endcase
        end
        send_req(mode, size, al, 0, no_check);
      end
    end

    // Drain, then give the block time to show any stray transfer.
    req_if.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
